// File: hdl/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Types and constants shared by the positional ordered list and its checker.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // Width wide enough to compare a position field against the count.
  localparam int WIDE_W = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [2:0] ACT_INSERT   = 3'd0;
  localparam logic [2:0] ACT_APPEND   = 3'd1;
  localparam logic [2:0] ACT_READ     = 3'd2;
  localparam logic [2:0] ACT_DELETE   = 3'd3;
  localparam logic [2:0] ACT_READ_END = 3'd4;
  localparam logic [2:0] ACT_CLEAR    = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  position;
    logic [31:0] data_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [6:0]  entry_count;
  } rsp_t;

endpackage

// File: hdl/positional_ordered_list_unit.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_unit
// Ordered list of data words in one synchronous memory; insert and delete
// move the later words one entry per cycle through a read/write pipeline.
// ----------------------------------------------------------------------------
//  channel | signals                     | payload
//  --------+-----------------------------+---------------------------------
//  request | req_valid / req_ready       | req  (action, position, data_in)
//  result  | rsp_valid / rsp_ready       | rsp  (status, data_out, entry_count)
//
// One request is worked on at a time. Insert passes the shift, drain and put
// states (only put with nothing to move), append put, delete shift and drain
// (neither with nothing to move), reads read and read wait, others none; the
// result turns valid from done. Shift reads and writes one moved word each
// time; moves counts the words from the position on (insert) or after it
// (delete). The next request can transfer from the cycle in which the result
// turns valid. Reset clears the count and the handshake state only; the
// memory needs no clearing. A stalled result holds the unit in its final
// state, and a new request is taken once the result has moved to the output.
// ----------------------------------------------------------------------------
module positional_ordered_list_unit
  import pol_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_RDWT  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]            state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      moves;
  logic                  shift_up;
  logic [ADDR_W-1:0]     rd_idx;
  logic [ADDR_W-1:0]     put_idx;
  logic [DATA_WIDTH-1:0] put_word;
  logic                  pend;
  logic [ADDR_W-1:0]     pend_idx;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  rsp_t                  res;

  logic [WIDE_W-1:0]     cnt_w;
  logic [WIDE_W-1:0]     pos_w;
  logic [CNT_W-1:0]      pos_c;
  logic                  full;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  assign cnt_w = WIDE_W'(count);
  assign pos_w = WIDE_W'(req.position);
  assign pos_c = CNT_W'(req.position);
  assign full  = (count == CNT_W'(CAPACITY));

  assign req_ready = (state == S_IDLE);

  // The single write port serves either a pending shifted word or the new word.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_idx;
    wr_data = rd_data;
    if (state == S_PUT) begin
      wr_en   = 1'b1;
      wr_addr = put_idx;
      wr_data = put_word;
    end else if (pend) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      pend <= (state == S_SHIFT);

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            res.status   <= ST_OK;
            res.data_out <= '0;
            put_idx      <= ADDR_W'(req.position);
            put_word     <= DATA_WIDTH'(req.data_in);
            state        <= S_DONE;
            case (req.action)
              ACT_INSERT, ACT_APPEND: begin
                if (req.action == ACT_INSERT && pos_w > cnt_w) begin
                  res.status <= ST_RANGE;
                end else if (full) begin
                  res.status <= ST_FULL;
                end else begin
                  shift_up <= 1'b1;
                  rd_idx   <= ADDR_W'(count - 1'b1);
                  count    <= count + 1'b1;
                  if (req.action == ACT_APPEND) begin
                    put_idx <= ADDR_W'(count);
                    moves   <= '0;
                    state   <= S_PUT;
                  end else begin
                    moves <= count - pos_c;
                    state <= (count == pos_c) ? S_PUT : S_SHIFT;
                  end
                  res.entry_count <= 7'(count + 1'b1);
                end
              end
              ACT_DELETE: begin
                if (pos_w >= cnt_w) begin
                  res.status <= ST_RANGE;
                end else begin
                  shift_up <= 1'b0;
                  rd_idx   <= ADDR_W'(pos_c + 1'b1);
                  moves    <= count - pos_c - 1'b1;
                  count    <= count - 1'b1;
                  state    <= (count - pos_c == CNT_W'(1)) ? S_DONE : S_SHIFT;
                end
              end
              ACT_READ: begin
                if (pos_w >= cnt_w) begin
                  res.status <= ST_RANGE;
                end else begin
                  rd_idx <= ADDR_W'(req.position);
                  state  <= S_RD;
                end
              end
              ACT_READ_END: begin
                if (req.position == 7'd0 || pos_w > cnt_w) begin
                  res.status <= ST_RANGE;
                end else begin
                  rd_idx <= ADDR_W'(count - pos_c);
                  state  <= S_RD;
                end
              end
              ACT_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
            // Count after the request; a successful insert or append sets it in its own branch.
            if (!((req.action == ACT_INSERT || req.action == ACT_APPEND) &&
                  !(req.action == ACT_INSERT && pos_w > cnt_w) && !full)) begin
              if (req.action == ACT_CLEAR) begin
                res.entry_count <= '0;
              end else if (req.action == ACT_DELETE && pos_w < cnt_w) begin
                res.entry_count <= 7'(count - 1'b1);
              end else begin
                res.entry_count <= 7'(count);
              end
            end
          end
        end
        S_SHIFT: begin
          // Read one word; it is written one entry up or down next cycle.
          pend_idx <= shift_up ? rd_idx + 1'b1 : rd_idx - 1'b1;
          rd_idx   <= shift_up ? rd_idx - 1'b1 : rd_idx + 1'b1;
          moves    <= moves - 1'b1;
          if (moves == CNT_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= shift_up ? S_PUT : S_DONE;
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_RD: begin
          state <= S_RDWT;
        end
        S_RDWT: begin
          res.data_out <= 32'(rd_data);
          state        <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/pol_checker.sv
// ----------------------------------------------------------------------------
// pol_checker
// Port-level checks for the positional ordered list, bound to its top level.
// ----------------------------------------------------------------------------
module pol_checker
  import pol_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // A stalled result keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Requests are worked on one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  // A failed request returns no word.
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.data_out == '0)
    else $error("failed request returned data");

  // A full status only appears with the list at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == 7'(CAPACITY))
    else $error("full status with list below capacity");

endmodule

bind positional_ordered_list_unit pol_checker u_pol_checker (.*);
